[rtl/afp_pkg.sv]
`timescale 1ns / 1ps
package afp_pkg;

	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int KP_W     = 2 * COORD_W;
	localparam int K_W      = 2 * COORD_W + 1;
	localparam int DP_W     = 2 * COORD_W + 2;
	localparam int DET_W    = 2 * COORD_W + 3;
	localparam int SP_W     = 3 * COORD_W + 1;
	localparam int NS_W     = 3 * COORD_W + 3;
	localparam int COEF_W   = 32;
	localparam int SHIFT_W  = 48;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SINGULAR  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] src_x0;
		logic signed [COORD_W-1:0] src_y0;
		logic signed [COORD_W-1:0] src_x1;
		logic signed [COORD_W-1:0] src_y1;
		logic signed [COORD_W-1:0] src_x2;
		logic signed [COORD_W-1:0] src_y2;
		logic signed [COORD_W-1:0] dst_x0;
		logic signed [COORD_W-1:0] dst_y0;
		logic signed [COORD_W-1:0] dst_x1;
		logic signed [COORD_W-1:0] dst_y1;
		logic signed [COORD_W-1:0] dst_x2;
		logic signed [COORD_W-1:0] dst_y2;
	} pts_t;

	typedef struct packed {
		logic signed [COEF_W-1:0]  coef_a;
		logic signed [COEF_W-1:0]  coef_b;
		logic signed [SHIFT_W-1:0] shift_s;
		logic signed [COEF_W-1:0]  coef_c;
		logic signed [COEF_W-1:0]  coef_d;
		logic signed [SHIFT_W-1:0] shift_t;
		logic [STATUS_W-1:0]       status;
	} map_t;

	// numerators and determinant of one item, queued between front and back
	typedef struct packed {
		logic                    sing;
		logic signed [DET_W-1:0] det;
		logic signed [DET_W-1:0] na;
		logic signed [DET_W-1:0] nb;
		logic signed [DET_W-1:0] nc;
		logic signed [DET_W-1:0] nd;
		logic signed [NS_W-1:0]  ns;
		logic signed [NS_W-1:0]  nt;
	} entry_t;

endpackage

[rtl/affine_from_three_point_pairs.sv]
`timescale 1ns / 1ps
// channel | dir | handshake             | payload
// pts     | in  | pts_valid / pts_stall | pts_t: three source and three target points
// map     | out | map_valid / map_stall | map_t: a, b, s, c, d, t and status
//
// one item per cycle sustained while map is not stalled; an item passes the front
// stages, the queue, a setup register, 48 divider steps and the output register
// the latency is set by the 48-step restoring divider pipelines, one per coefficient
// arst_n clears all valid flags and queue pointers; payload registers are not reset
// a stall on map freezes the back end; the queue then fills and pts_stall rises
module affine_from_three_point_pairs import afp_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pts_valid,
	output logic pts_stall,
	input  pts_t pts,
	output logic map_valid,
	input  logic map_stall,
	output map_t map
);

	// front to queue
	entry_t f_entry;
	logic   f_push;
	// queue to back
	entry_t q_head;
	logic   q_full, q_empty, b_pop;

	// front: determinant and numerators, exact integer arithmetic
	afp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pts_valid(pts_valid),
		.pts_stall(pts_stall),
		.pts      (pts),
		.full     (q_full),
		.push     (f_push),
		.entry    (f_entry)
	);

	// decouples the front from output stalls
	afp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata (f_entry),
		.pop   (b_pop),
		.rdata (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	// back: six fixed point quotients with saturation
	afp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (q_head),
		.pop      (b_pop),
		.map_valid(map_valid),
		.map_stall(map_stall),
		.map      (map)
	);

endmodule

[rtl/afp_front.sv]
`timescale 1ns / 1ps
module afp_front import afp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pts_valid,
	output logic   pts_stall,
	input  pts_t   pts,
	input  logic   full,
	output logic   push,
	output entry_t entry
);

	logic en;
	logic v_s1, v_s2, v_s3;

	// stage 1: differences and cross products
	logic signed [DIFF_W-1:0]  dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [DIFF_W-1:0]  ex1_s1, ex2_s1, ey1_s1, ey2_s1;
	logic signed [KP_W-1:0]    x1y2_s1, x2y1_s1, x0y2_s1, x2y0_s1, x0y1_s1, x1y0_s1;
	logic signed [COORD_W-1:0] px0_s1, px1_s1, px2_s1, py0_s1, py1_s1, py2_s1;

	// stage 2: products of differences, minors
	logic signed [DP_W-1:0]    pd1_s2, pd2_s2, pa1_s2, pa2_s2, pb1_s2, pb2_s2;
	logic signed [DP_W-1:0]    pc1_s2, pc2_s2, pe1_s2, pe2_s2;
	logic signed [K_W-1:0]     k0_s2, k1_s2, k2_s2;
	logic signed [COORD_W-1:0] px0_s2, px1_s2, px2_s2, py0_s2, py1_s2, py2_s2;

	// stage 3: determinant, numerators, translation partial products
	logic signed [DET_W-1:0] det_s3, na_s3, nb_s3, nc_s3, nd_s3;
	logic signed [SP_W-1:0]  sx0_s3, sx1_s3, sx2_s3, sy0_s3, sy1_s3, sy2_s3;

	assign en        = !(v_s3 && full);
	assign pts_stall = !en;
	assign push      = v_s3 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pts_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s1  <= DIFF_W'(pts.src_x1) - DIFF_W'(pts.src_x0);
			dy1_s1  <= DIFF_W'(pts.src_y1) - DIFF_W'(pts.src_y0);
			dx2_s1  <= DIFF_W'(pts.src_x2) - DIFF_W'(pts.src_x0);
			dy2_s1  <= DIFF_W'(pts.src_y2) - DIFF_W'(pts.src_y0);
			ex1_s1  <= DIFF_W'(pts.dst_x1) - DIFF_W'(pts.dst_x0);
			ex2_s1  <= DIFF_W'(pts.dst_x2) - DIFF_W'(pts.dst_x0);
			ey1_s1  <= DIFF_W'(pts.dst_y1) - DIFF_W'(pts.dst_y0);
			ey2_s1  <= DIFF_W'(pts.dst_y2) - DIFF_W'(pts.dst_y0);
			x1y2_s1 <= KP_W'(pts.src_x1) * KP_W'(pts.src_y2);
			x2y1_s1 <= KP_W'(pts.src_x2) * KP_W'(pts.src_y1);
			x0y2_s1 <= KP_W'(pts.src_x0) * KP_W'(pts.src_y2);
			x2y0_s1 <= KP_W'(pts.src_x2) * KP_W'(pts.src_y0);
			x0y1_s1 <= KP_W'(pts.src_x0) * KP_W'(pts.src_y1);
			x1y0_s1 <= KP_W'(pts.src_x1) * KP_W'(pts.src_y0);
			px0_s1  <= pts.dst_x0;
			px1_s1  <= pts.dst_x1;
			px2_s1  <= pts.dst_x2;
			py0_s1  <= pts.dst_y0;
			py1_s1  <= pts.dst_y1;
			py2_s1  <= pts.dst_y2;

			pd1_s2 <= DP_W'(dx1_s1) * DP_W'(dy2_s1);
			pd2_s2 <= DP_W'(dx2_s1) * DP_W'(dy1_s1);
			pa1_s2 <= DP_W'(ex1_s1) * DP_W'(dy2_s1);
			pa2_s2 <= DP_W'(ex2_s1) * DP_W'(dy1_s1);
			pb1_s2 <= DP_W'(dx1_s1) * DP_W'(ex2_s1);
			pb2_s2 <= DP_W'(dx2_s1) * DP_W'(ex1_s1);
			pc1_s2 <= DP_W'(ey1_s1) * DP_W'(dy2_s1);
			pc2_s2 <= DP_W'(ey2_s1) * DP_W'(dy1_s1);
			pe1_s2 <= DP_W'(dx1_s1) * DP_W'(ey2_s1);
			pe2_s2 <= DP_W'(dx2_s1) * DP_W'(ey1_s1);
			k0_s2  <= K_W'(x1y2_s1) - K_W'(x2y1_s1);
			k1_s2  <= K_W'(x0y2_s1) - K_W'(x2y0_s1);
			k2_s2  <= K_W'(x0y1_s1) - K_W'(x1y0_s1);
			px0_s2 <= px0_s1;
			px1_s2 <= px1_s1;
			px2_s2 <= px2_s1;
			py0_s2 <= py0_s1;
			py1_s2 <= py1_s1;
			py2_s2 <= py2_s1;

			det_s3 <= DET_W'(pd1_s2) - DET_W'(pd2_s2);
			na_s3  <= DET_W'(pa1_s2) - DET_W'(pa2_s2);
			nb_s3  <= DET_W'(pb1_s2) - DET_W'(pb2_s2);
			nc_s3  <= DET_W'(pc1_s2) - DET_W'(pc2_s2);
			nd_s3  <= DET_W'(pe1_s2) - DET_W'(pe2_s2);
			sx0_s3 <= SP_W'(px0_s2) * SP_W'(k0_s2);
			sx1_s3 <= SP_W'(px1_s2) * SP_W'(k1_s2);
			sx2_s3 <= SP_W'(px2_s2) * SP_W'(k2_s2);
			sy0_s3 <= SP_W'(py0_s2) * SP_W'(k0_s2);
			sy1_s3 <= SP_W'(py1_s2) * SP_W'(k1_s2);
			sy2_s3 <= SP_W'(py2_s2) * SP_W'(k2_s2);
		end
	end

	// collinear source points show up as a zero determinant
	always_comb begin
		entry.sing = (det_s3 == '0);
		entry.det  = det_s3;
		entry.na   = na_s3;
		entry.nb   = nb_s3;
		entry.nc   = nc_s3;
		entry.nd   = nd_s3;
		entry.ns   = NS_W'(sx0_s3) - NS_W'(sx1_s3) + NS_W'(sx2_s3);
		entry.nt   = NS_W'(sy0_s3) - NS_W'(sy1_s3) + NS_W'(sy2_s3);
	end

endmodule

[rtl/afp_queue.sv]
`timescale 1ns / 1ps
module afp_queue import afp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	input  logic   pop,
	output entry_t rdata,
	output logic   full,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty) else $error("queue lost an item");

endmodule

[rtl/afp_div.sv]
`timescale 1ns / 1ps
module afp_div #(
	parameter int NUM_W     = 35,
	parameter int DEN_W     = 35,
	parameter int Q_W       = 32,
	parameter int STAGES    = 48,
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic [Q_W-1:0]          res,
	output logic                    sat
);

	localparam int NW = NUM_W + FRAC_BITS;
	localparam int NX = (NW > Q_W) ? NW : Q_W + 1;
	localparam int TW = NX - Q_W;
	localparam int CW = (TW > DEN_W) ? TW : DEN_W;

	logic [DEN_W-1:0] rem_s [STAGES+1];
	logic [Q_W-1:0]   nl_s  [STAGES+1];
	logic [Q_W-1:0]   q_s   [STAGES+1];
	logic [DEN_W-1:0] dm_s  [STAGES+1];
	logic             neg_s [STAGES+1];
	logic             ovf_s [STAGES+1];

	logic [DEN_W-1:0] rem_n [STAGES];
	logic [Q_W-1:0]   nl_n  [STAGES];
	logic [Q_W-1:0]   q_n   [STAGES];

	logic [NUM_W-1:0] num_u, nm;
	logic [DEN_W-1:0] den_u, dm;
	logic [NX-1:0]    nx;
	logic [TW-1:0]    top;
	logic             ovf0;

	// magnitudes; quotient bits above Q_W only matter as overflow
	always_comb begin
		num_u = num;
		den_u = den;
		nm    = num[NUM_W-1] ? NUM_W'(~num_u + 1'b1) : num_u;
		dm    = den[DEN_W-1] ? DEN_W'(~den_u + 1'b1) : den_u;
		nx    = NX'(nm) << FRAC_BITS;
		top   = nx[NX-1:Q_W];
		ovf0  = CW'(top) >= CW'(dm);
	end

	// one restoring step per stage for the first Q_W stages; later stages pass values through
	always_comb begin
		logic [DEN_W:0] t;
		logic           ge;
		for (int k = 0; k < STAGES; k++) begin
			t  = {rem_s[k], nl_s[k][Q_W-1]};
			ge = (t >= {1'b0, dm_s[k]});
			if (k < Q_W) begin
				rem_n[k] = ge ? DEN_W'(t - {1'b0, dm_s[k]}) : t[DEN_W-1:0];
				nl_n[k]  = nl_s[k] << 1;
				q_n[k]   = (q_s[k] << 1) | Q_W'(ge);
			end else begin
				rem_n[k] = rem_s[k];
				nl_n[k]  = nl_s[k];
				q_n[k]   = q_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(top);
			nl_s[0]  <= nx[Q_W-1:0];
			q_s[0]   <= '0;
			dm_s[0]  <= dm;
			neg_s[0] <= num[NUM_W-1] ^ den[DEN_W-1];
			ovf_s[0] <= ovf0;
			for (int k = 0; k < STAGES; k++) begin
				rem_s[k+1] <= rem_n[k];
				nl_s[k+1]  <= nl_n[k];
				q_s[k+1]   <= q_n[k];
				dm_s[k+1]  <= dm_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// saturate toward the side of the true value, then apply sign
	always_comb begin
		logic [Q_W-1:0] limit;
		logic [Q_W-1:0] val;
		logic           over;
		limit = neg_s[STAGES] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		over  = ovf_s[STAGES] || (q_s[STAGES] > limit);
		val   = over ? limit : q_s[STAGES];
		res   = neg_s[STAGES] ? Q_W'(~val + 1'b1) : val;
		sat   = over;
	end

endmodule

[rtl/afp_back.sv]
`timescale 1ns / 1ps
module afp_back import afp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   empty,
	input  entry_t head,
	output logic   pop,
	output logic   map_valid,
	input  logic   map_stall,
	output map_t   map
);

	localparam int STAGES = SHIFT_W;

	logic                en;
	logic                v_s   [STAGES+1];
	logic                sng_s [STAGES+1];
	logic                map_valid_q;
	map_t                map_q;
	logic [COEF_W-1:0]   ra, rb, rc, rd;
	logic [SHIFT_W-1:0]  rs, rt;
	logic [5:0]          sat;

	assign en        = !(map_valid_q && map_stall);
	assign pop       = !empty && en;
	assign map_valid = map_valid_q;
	assign map       = map_q;

	afp_div #(.NUM_W(DET_W), .DEN_W(DET_W), .Q_W(COEF_W), .STAGES(STAGES),
		.FRAC_BITS(FRAC_BITS)) u_div_a (.clk(clk), .en(en), .num(head.na),
		.den(head.det), .res(ra), .sat(sat[0]));
	afp_div #(.NUM_W(DET_W), .DEN_W(DET_W), .Q_W(COEF_W), .STAGES(STAGES),
		.FRAC_BITS(FRAC_BITS)) u_div_b (.clk(clk), .en(en), .num(head.nb),
		.den(head.det), .res(rb), .sat(sat[1]));
	afp_div #(.NUM_W(NS_W), .DEN_W(DET_W), .Q_W(SHIFT_W), .STAGES(STAGES),
		.FRAC_BITS(FRAC_BITS)) u_div_s (.clk(clk), .en(en), .num(head.ns),
		.den(head.det), .res(rs), .sat(sat[2]));
	afp_div #(.NUM_W(DET_W), .DEN_W(DET_W), .Q_W(COEF_W), .STAGES(STAGES),
		.FRAC_BITS(FRAC_BITS)) u_div_c (.clk(clk), .en(en), .num(head.nc),
		.den(head.det), .res(rc), .sat(sat[3]));
	afp_div #(.NUM_W(DET_W), .DEN_W(DET_W), .Q_W(COEF_W), .STAGES(STAGES),
		.FRAC_BITS(FRAC_BITS)) u_div_d (.clk(clk), .en(en), .num(head.nd),
		.den(head.det), .res(rd), .sat(sat[4]));
	afp_div #(.NUM_W(NS_W), .DEN_W(DET_W), .Q_W(SHIFT_W), .STAGES(STAGES),
		.FRAC_BITS(FRAC_BITS)) u_div_t (.clk(clk), .en(en), .num(head.nt),
		.den(head.det), .res(rt), .sat(sat[5]));

	// valid and singular flag ride along the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++)
				v_s[k] <= 1'b0;
			map_valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= pop;
			for (int k = 0; k < STAGES; k++)
				v_s[k+1] <= v_s[k];
			map_valid_q <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sng_s[0] <= head.sing;
			for (int k = 0; k < STAGES; k++)
				sng_s[k+1] <= sng_s[k];
			if (v_s[STAGES]) begin
				if (sng_s[STAGES]) begin
					map_q.coef_a  <= '0;
					map_q.coef_b  <= '0;
					map_q.shift_s <= '0;
					map_q.coef_c  <= '0;
					map_q.coef_d  <= '0;
					map_q.shift_t <= '0;
					map_q.status  <= STATUS_SINGULAR;
				end else begin
					map_q.coef_a  <= ra;
					map_q.coef_b  <= rb;
					map_q.shift_s <= rs;
					map_q.coef_c  <= rc;
					map_q.coef_d  <= rd;
					map_q.shift_t <= rt;
					map_q.status  <= (sat != '0) ? STATUS_SATURATED : STATUS_OK;
				end
			end
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import afp_pkg::*;

	// exact affine solve, one map per point set
	class map_scoreboard;
		map_t pending[$];
		int errors = 0;

		// truncating fixed point divide with saturation to w bits
		function automatic logic signed [63:0] fx_quot(logic signed [63:0] num,
				logic signed [63:0] den, int w, ref bit sat);
			logic signed [127:0] n, q, lim_hi, lim_lo;
			n = 128'(num) <<< 16;
			q = n / 128'(den);
			lim_hi = (128'sd1 <<< (w - 1)) - 1;
			lim_lo = -(128'sd1 <<< (w - 1));
			if (q > lim_hi) begin
				sat = 1;
				q = lim_hi;
			end else if (q < lim_lo) begin
				sat = 1;
				q = lim_lo;
			end
			return q[63:0];
		endfunction

		function void note_points(pts_t p);
			logic signed [63:0] x0, y0, x1, y1, x2, y2, u0, v0, u1, v1, u2, v2;
			logic signed [63:0] dx1, dy1, dx2, dy2, det, k0, k1, k2;
			logic signed [63:0] na, nb, nc, nd, ns, nt;
			map_t m;
			bit sat;
			x0 = p.src_x0; y0 = p.src_y0; x1 = p.src_x1;
			y1 = p.src_y1; x2 = p.src_x2; y2 = p.src_y2;
			u0 = p.dst_x0; v0 = p.dst_y0; u1 = p.dst_x1;
			v1 = p.dst_y1; u2 = p.dst_x2; v2 = p.dst_y2;
			dx1 = x1 - x0; dy1 = y1 - y0; dx2 = x2 - x0; dy2 = y2 - y0;
			det = dx1 * dy2 - dx2 * dy1;
			m = '0;
			sat = 0;
			if (det == 0) begin
				m.status = STATUS_SINGULAR;
			end else begin
				k0 = x1 * y2 - x2 * y1;
				k1 = x0 * y2 - x2 * y0;
				k2 = x0 * y1 - x1 * y0;
				na = (u1 - u0) * dy2 - (u2 - u0) * dy1;
				nb = dx1 * (u2 - u0) - dx2 * (u1 - u0);
				nc = (v1 - v0) * dy2 - (v2 - v0) * dy1;
				nd = dx1 * (v2 - v0) - dx2 * (v1 - v0);
				// translation numerators fit 51 bits, 64 is plenty
				ns = u0 * k0 - u1 * k1 + u2 * k2;
				nt = v0 * k0 - v1 * k1 + v2 * k2;
				m.coef_a = COEF_W'(fx_quot(na, det, COEF_W, sat));
				m.coef_b = COEF_W'(fx_quot(nb, det, COEF_W, sat));
				m.shift_s = SHIFT_W'(fx_quot(ns, det, SHIFT_W, sat));
				m.coef_c = COEF_W'(fx_quot(nc, det, COEF_W, sat));
				m.coef_d = COEF_W'(fx_quot(nd, det, COEF_W, sat));
				m.shift_t = SHIFT_W'(fx_quot(nt, det, SHIFT_W, sat));
				m.status = sat ? STATUS_SATURATED : STATUS_OK;
			end
			pending.push_back(m);
		endfunction

		function void check_map(map_t got);
			map_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected map item %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.coef_a !== want.coef_a)
				$display("%0t: coef_a exp %h got %h", $time, want.coef_a, got.coef_a);
			if (got.coef_b !== want.coef_b)
				$display("%0t: coef_b exp %h got %h", $time, want.coef_b, got.coef_b);
			if (got.shift_s !== want.shift_s)
				$display("%0t: shift_s exp %h got %h", $time, want.shift_s, got.shift_s);
			if (got.coef_c !== want.coef_c)
				$display("%0t: coef_c exp %h got %h", $time, want.coef_c, got.coef_c);
			if (got.coef_d !== want.coef_d)
				$display("%0t: coef_d exp %h got %h", $time, want.coef_d, got.coef_d);
			if (got.shift_t !== want.shift_t)
				$display("%0t: shift_t exp %h got %h", $time, want.shift_t, got.shift_t);
			if (got.status !== want.status)
				$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
			if (got !== want)
				errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic pts_valid = 0;
	logic pts_stall;
	pts_t pts = '0;
	logic map_valid;
	logic map_stall = 0;
	map_t map;

	map_scoreboard sb = new();
	bit stim_done = 0;
	int stall_mode = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	affine_from_three_point_pairs dut (
		.clk(clk), .arst_n(arst_n),
		.pts_valid(pts_valid), .pts_stall(pts_stall), .pts(pts),
		.map_valid(map_valid), .map_stall(map_stall), .map(map)
	);

	// check on the rising edge, both sides settled since the falling edge
	always @(posedge clk) begin
		if (arst_n && map_valid && !map_stall)
			sb.check_map(map);
	end

	// receiver stall pattern: phases of none, light, heavy and periodic stalls
	always @(negedge clk) begin
		case (stall_mode)
		0: map_stall <= 0;
		1: map_stall <= ($urandom_range(0, 9) < 2);
		2: map_stall <= ($urandom_range(0, 9) < 7);
		default: map_stall <= ($time % 14) < 6;
		endcase
	end
	always begin
		repeat (200) @(posedge clk);
		stall_mode = $urandom_range(0, 3);
	end

	// random coordinate, biased toward the extremes and small values
	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 9))
		0: return 16'h8000;
		1: return 16'h7fff;
		2: return 16'(int'($urandom_range(0, 8)) - 4);
		3: return 16'(int'($urandom_range(0, 200)) - 100);
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic pts_t rand_points();
		pts_t p;
		int k;
		logic signed [15:0] ax, ay;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		k = $urandom_range(0, 9);
		if (k < 4) begin
			p.src_x0 = rand_coord(); p.src_y0 = rand_coord();
			p.src_x1 = rand_coord(); p.src_y1 = rand_coord();
			p.src_x2 = rand_coord(); p.src_y2 = rand_coord();
			p.dst_x0 = rand_coord(); p.dst_y0 = rand_coord();
			p.dst_x1 = rand_coord(); p.dst_y1 = rand_coord();
			p.dst_x2 = rand_coord(); p.dst_y2 = rand_coord();
		end else if (k == 4) begin
			// collinear source points
			ax = 16'($urandom_range(0, 40)) - 16'sd20;
			ay = 16'($urandom_range(0, 40)) - 16'sd20;
			p.src_x1 = p.src_x0 + ax;
			p.src_y1 = p.src_y0 + ay;
			p.src_x2 = p.src_x0 - 16'(2) * ax;
			p.src_y2 = p.src_y0 - 16'(2) * ay;
		end else if (k == 5) begin
			// tiny triangle with random full-range targets to provoke saturation
			p.src_x1 = p.src_x0 + 16'sd1;
			p.src_y1 = p.src_y0;
			p.src_x2 = p.src_x0;
			p.src_y2 = p.src_y0 + 16'sd1;
		end
		return p;
	endfunction

	task automatic send_points(pts_t p);
		pts <= p;
		pts_valid <= 1;
		@(posedge clk);
		while (pts_stall)
			@(posedge clk);
		sb.note_points(p);
		@(negedge clk);
	endtask

	task automatic idle_sender();
		pts_valid <= 0;
		pts <= '0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	initial begin
		pts_t p;
		int burst;
		int n;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: identity, extremes, singular cases, saturation and truncation
		p = '0;
		p.src_x1 = 16'sd1; p.src_y2 = 16'sd1;
		p.dst_x1 = 16'sd1; p.dst_y2 = 16'sd1;
		send_points(p);
		p.dst_x0 = 16'sh7fff; p.dst_y0 = 16'sh8000;
		send_points(p);
		p = '0;
		send_points(p);   // all points coincide
		p = {16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000};
		send_points(p);
		p = {16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
			16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff};
		send_points(p);
		p = {16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1,
			16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff};
		send_points(p);   // huge slope on a unit triangle
		p = {16'd1, 16'd1, 16'd2, 16'd2, 16'd3, 16'd3,
			16'd5, 16'd6, 16'd7, 16'd8, 16'd9, 16'd10};
		send_points(p);   // collinear on a diagonal
		p = {16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
		send_points(p);
		p = {16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 16'd7,
			16'd1, 16'hfffe, 16'd2, 16'd5, 16'hfff9, 16'd4};
		send_points(p);   // non-integer truncation both signs
		p = {16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
			16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff};
		send_points(p);
		for (int i = 0; i < 10; i++)
			send_points(rand_points());

		// random bursts
		n = 0;
		while (n < 1950) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++)
				send_points(rand_points());
			n += burst;
			if ($urandom_range(0, 3) != 0)
				idle_sender();
		end
		pts_valid <= 0;
		stim_done = 1;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("affine_from_three_point_pairs regression: pass");
		else
			$display("affine_from_three_point_pairs regression: fail");
		$finish;
	end

	// watchdog, far above the slowest stalled run
	initial begin
		#2000000;
		$display("affine_from_three_point_pairs regression: fail");
		$finish;
	end

endmodule

[filelist.f]
rtl/afp_pkg.sv
rtl/afp_front.sv
rtl/afp_queue.sv
rtl/afp_div.sv
rtl/afp_back.sv
rtl/affine_from_three_point_pairs.sv
tb/testbench.sv
